// ----- src/sfhw_pkg.sv -----
// shared types and constants for the sample fifo with high-water mark
`default_nettype none

package sfhw_pkg;

    // sample and field widths
    localparam int SAMPLE_W = 16;
    localparam int HWM_W    = 5;
    localparam int LEVEL_W  = 4;

    // high-water mark after reset, before saturation to the depth
    localparam logic [HWM_W-1:0] HWM_RESET = 5'd16;

    // request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // one finished request as the controller reports it
    typedef struct packed {
        logic               valid;
        logic               accepted;
        logic               pop_ok;
        logic [LEVEL_W-1:0] fill;
        logic [LEVEL_W-1:0] space;
    } t_result;

endpackage

`default_nettype wire

// ----- src/sfhw_ram.sv -----
// generic single-clock ram, one write and one registered read port
`default_nettype none

module sfhw_ram #(
    parameter int W = 16,
    parameter int D = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                      i_wdata,
    input  wire logic                              i_re,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic      [W-1:0]                      o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/sfhw_ctrl.sv -----
// ring pointers, fill count, high-water mark and per-request decision
`default_nettype none

module sfhw_ctrl #(
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic                                   i_req_type,
    input  wire logic signed [sfhw_pkg::SAMPLE_W-1:0]   i_push_sample,
    input  wire logic                                   i_cfg_we,
    input  wire logic [sfhw_pkg::HWM_W-1:0]             i_cfg_wdata,
    output logic                                        o_ram_we,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_ram_waddr,
    output logic [sfhw_pkg::SAMPLE_W-1:0]               o_ram_wdata,
    output logic                                        o_ram_re,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] o_ram_raddr,
    output sfhw_pkg::t_result                           o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ((AW + 1) > 6) ? (AW + 1) : 6;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] HWM_RST =
        ({{(CW-sfhw_pkg::HWM_W){1'b0}}, sfhw_pkg::HWM_RESET} > DEPTH_C) ?
        DEPTH_C : {{(CW-sfhw_pkg::HWM_W){1'b0}}, sfhw_pkg::HWM_RESET};
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_fill,   n_fill;
    logic [CW-1:0] r_hwm,    n_hwm;
    sfhw_pkg::t_result r_res, n_res;

    logic          push_ok;
    logic          pop_ok;
    logic [CW-1:0] cur_space;
    logic [CW-1:0] new_space;
    logic [CW-1:0] cfg_ext;

    // pushes still allowed: min of free slots and mark minus fill
    function automatic logic [CW-1:0] space_of(input logic [AW-1:0] fill,
                                               input logic [CW-1:0] hwm);
        logic [CW-1:0] fill_ext;
        logic [CW-1:0] free_slots;
        logic [CW-1:0] under;
        fill_ext   = {{(CW-AW){1'b0}}, fill};
        free_slots = DEPTH_C - CW'(1) - fill_ext;
        under      = (hwm > fill_ext) ? (hwm - fill_ext) : '0;
        return (under < free_slots) ? under : free_slots;
    endfunction

    // request decision against the current state
    always_comb begin
        cur_space = space_of(r_fill, r_hwm);
        push_ok   = i_start && (i_req_type == sfhw_pkg::REQ_PUSH) && (cur_space != '0);
        pop_ok    = i_start && (i_req_type == sfhw_pkg::REQ_POP) && (r_fill != '0);
    end

    // pointer and fill update
    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_fill   = r_fill;
        if (push_ok) begin
            n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + AW'(1);
            n_fill   = r_fill + AW'(1);
        end
        if (pop_ok) begin
            n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + AW'(1);
            n_fill   = r_fill - AW'(1);
        end
    end

    // mark write, saturated to the depth
    always_comb begin
        cfg_ext = {{(CW-sfhw_pkg::HWM_W){1'b0}}, i_cfg_wdata};
        n_hwm   = r_hwm;
        if (i_cfg_we) begin
            n_hwm = (cfg_ext > DEPTH_C) ? DEPTH_C : cfg_ext;
        end
    end

    // status after the request
    always_comb begin
        logic [CW-1:0] fill_ext;
        fill_ext       = {{(CW-AW){1'b0}}, n_fill};
        new_space      = space_of(n_fill, r_hwm);
        n_res.valid    = i_start;
        n_res.accepted = push_ok || pop_ok;
        n_res.pop_ok   = pop_ok;
        n_res.fill     = fill_ext[sfhw_pkg::LEVEL_W-1:0];
        n_res.space    = new_space[sfhw_pkg::LEVEL_W-1:0];
    end

    // control state and result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_fill      <= '0;
            r_hwm       <= HWM_RST;
            r_res.valid <= 1'b0;
        end else begin
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_fill      <= n_fill;
            r_hwm       <= n_hwm;
            r_res.valid <= n_res.valid;
        end
        r_res.accepted <= n_res.accepted;
        r_res.pop_ok   <= n_res.pop_ok;
        r_res.fill     <= n_res.fill;
        r_res.space    <= n_res.space;
    end

    // memory requests
    assign o_ram_we    = push_ok;
    assign o_ram_waddr = r_wr_idx;
    assign o_ram_wdata = i_push_sample;
    assign o_ram_re    = pop_ok;
    assign o_ram_raddr = r_rd_idx;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ----- src/sample_fifo_high_water.sv -----
// Sample FIFO with high-water mark: signed 16-bit samples in a ring of DEPTH
// slots held in one synchronous memory, at most DEPTH-1 samples stored. Each
// request (i_start) is a push or a pop: a request is taken every cycle (o_busy
// stays low) and its result appears on o_done in the cycle after, from the
// controller's result register; a popped sample comes from the registered read
// of the sample memory issued at the edge that takes the pop. The receiver
// cannot stall the result. A push is stored only while space is nonzero, space
// being the smaller of the free slots and the high-water mark minus the fill
// level, never below zero. The mark resets to min(16, DEPTH), and writes above
// DEPTH saturate to DEPTH; write it only while no request is in flight.
`default_nettype none

module sample_fifo_high_water #(
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    output logic                                       o_busy,
    input  wire logic                                  i_req_type,
    input  wire logic signed [sfhw_pkg::SAMPLE_W-1:0]  i_push_sample,
    input  wire logic                                  i_cfg_we,
    input  wire logic [sfhw_pkg::HWM_W-1:0]            i_cfg_wdata,
    output logic                                       o_done,
    output logic                                       o_accepted,
    output logic signed [sfhw_pkg::SAMPLE_W-1:0]       o_pop_sample,
    output logic [sfhw_pkg::LEVEL_W-1:0]               o_fill_level,
    output logic [sfhw_pkg::LEVEL_W-1:0]               o_space_left
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [sfhw_pkg::SAMPLE_W-1:0] ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [sfhw_pkg::SAMPLE_W-1:0] ram_rdata;
    sfhw_pkg::t_result             res;

    // pointer and decision logic
    sfhw_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_req_type   (i_req_type),
        .i_push_sample(i_push_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .o_res        (res)
    );

    // sample storage
    sfhw_ram #(
        .W(sfhw_pkg::SAMPLE_W),
        .D(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // result ports
    assign o_busy       = 1'b0;
    assign o_done       = res.valid;
    assign o_accepted   = res.accepted;
    assign o_pop_sample = res.pop_ok ? $signed(ram_rdata) : '0;
    assign o_fill_level = res.fill;
    assign o_space_left = res.space;

endmodule

`default_nettype wire

// ----- src/sfhw_checker.sv -----
// port-level checks for the sample fifo, bound to the top level
`default_nettype none

module sfhw_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_start,
    input wire logic                                 o_busy,
    input wire logic                                 i_req_type,
    input wire logic                                 o_done,
    input wire logic                                 o_accepted,
    input wire logic signed [sfhw_pkg::SAMPLE_W-1:0] o_pop_sample,
    input wire logic [sfhw_pkg::LEVEL_W-1:0]         o_fill_level
);

    // one result for every request, in the cycle after it
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done == $past(i_start && !o_busy && i_rst_n))
        else $error("result strobe does not follow request");

    // failed request returns no sample
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_accepted) |-> (o_pop_sample == '0))
        else $error("failed request returned data");

    // a push never returns a sample
    a_push_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_req_type == sfhw_pkg::REQ_PUSH)) |-> (o_pop_sample == '0))
        else $error("push returned data");

    // back-to-back results move the fill level by at most one
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done) && $past(i_rst_n, 2)) |->
        ((o_fill_level == $past(o_fill_level)) ||
         (o_fill_level == sfhw_pkg::LEVEL_W'($past(o_fill_level) + 1'b1)) ||
         (o_fill_level == sfhw_pkg::LEVEL_W'($past(o_fill_level) - 1'b1))))
        else $error("fill level jumped");

    // a rejected request leaves the fill level as it was
    a_fail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_accepted && $past(o_done) && $past(i_rst_n, 2)) |->
        (o_fill_level == $past(o_fill_level)))
        else $error("rejected request changed fill level");

endmodule

bind sample_fifo_high_water sfhw_checker u_sfhw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_req_type  (i_req_type),
    .o_done      (o_done),
    .o_accepted  (o_accepted),
    .o_pop_sample(o_pop_sample),
    .o_fill_level(o_fill_level)
);

`default_nettype wire
